// ===== rtl/hlrgb_pkg.sv =====
// Shared types and constants for the hue/lightness to RGB converter.
// Holds the hue ramp table and the shading mode codes.
// No dependencies.
`timescale 1ns / 1ps

package hlrgb_pkg;

  localparam int RegionSteps = 40;
  localparam int FullScale   = 255;
  localparam int NumRegions  = 6;

  // Region code 6 and 7 mean the hue is out of range.
  typedef logic [2:0] region_t;
  localparam region_t RegionInvalid = region_t'(NumRegions);

  // How the lightness stage treats a channel.
  typedef enum logic [1:0] {
    SH_PASS   = 2'b00,
    SH_DARK   = 2'b01,
    SH_BRIGHT = 2'b10
  } shade_mode_t;

  // Load enables for the two shading stages.
  typedef struct packed {
    logic load_prod;
    logic load_out;
  } shade_ctl_t;

  typedef logic [RegionSteps-1:0][7:0] ramp_lut_t;

  // The rising ramp offset * 255 / 40, built once at elaboration.
  function automatic ramp_lut_t build_ramp();
    ramp_lut_t lut;
    for (int i = 0; i < RegionSteps; i++) begin
      lut[i] = 8'((i * FullScale) / RegionSteps);
    end
    return lut;
  endfunction

  localparam ramp_lut_t RampLut = build_ramp();

endpackage

// ===== rtl/hue_lightness_to_rgb.sv =====
// Top level of the hue/lightness to RGB converter at full saturation.
// Depends on hlrgb_pkg and hlrgb_shade.
`timescale 1ns / 1ps

// Usage:
// A beat on the hl channel carries a hue (0..239, six regions of 40) and a
// lightness byte. A beat is taken at a rising edge with hl_valid high and
// hl_stall low. Each beat gives one beat on the rgb channel with red, green
// and blue, and hue_invalid set when the hue is 240 or more (base color then
// black, still shaded by lightness).
// The pipeline has four register stages: region and ramp lookup, base color,
// per-channel multiply, then the divide and output register. One beat is taken
// every cycle while the pipeline is not held up by rgb_stall.
// The rate is set by the three 8x8 multipliers, one per channel, which start
// a new product every cycle unless the pipeline is stalled.
// When the receiver raises rgb_stall, the output holds and stages stop from
// the back only as far as they are full, so no beat is lost or repeated and
// empty stages still fill. hl_stall rises once every stage is full.
// A synchronous reset empties all stages; no result is pending afterward.

module hue_lightness_to_rgb (
  input  logic       clk,
  input  logic       rst,
  input  logic       hl_valid,
  output logic       hl_stall,
  input  logic [7:0] hue,
  input  logic [7:0] lightness,
  output logic       rgb_valid,
  input  logic       rgb_stall,
  output logic [7:0] red,
  output logic [7:0] green,
  output logic [7:0] blue,
  output logic       hue_invalid
);
  import hlrgb_pkg::*;

  logic en1, en2, en3, en_out;
  logic s1_valid, s2_valid, s3_valid;

  region_t    region_next;
  logic [7:0] floor_next;
  logic [7:0] offset_next;

  region_t    s1_region;
  logic [7:0] s1_ramp;
  logic [7:0] s1_light;

  logic [7:0]  r_next, g_next, b_next, k_next;
  shade_mode_t mode_next;
  logic [7:0]  s2_r, s2_g, s2_b, s2_k;
  shade_mode_t s2_mode;
  logic        s2_bad;
  logic        s3_bad;

  shade_ctl_t ctl;

  // Each stage moves when it is empty or the stage after it moves.
  always_comb begin
    en_out   = !rgb_valid || !rgb_stall;
    en3      = !s3_valid || en_out;
    en2      = !s2_valid || en3;
    en1      = !s1_valid || en2;
    hl_stall = !en1;
    ctl.load_prod = en3;
    ctl.load_out  = en_out;
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      s3_valid  <= 1'b0;
      rgb_valid <= 1'b0;
    end else begin
      if (en1)    s1_valid  <= hl_valid;
      if (en2)    s2_valid  <= s1_valid;
      if (en3)    s3_valid  <= s2_valid;
      if (en_out) rgb_valid <= s3_valid;
    end
  end

  // Stage 1: find the hue region by threshold compares, then the ramp value.
  always_comb begin
    if (hue < 8'(RegionSteps)) begin
      region_next = region_t'(0);
      floor_next  = 8'd0;
    end else if (hue < 8'(2 * RegionSteps)) begin
      region_next = region_t'(1);
      floor_next  = 8'(RegionSteps);
    end else if (hue < 8'(3 * RegionSteps)) begin
      region_next = region_t'(2);
      floor_next  = 8'(2 * RegionSteps);
    end else if (hue < 8'(4 * RegionSteps)) begin
      region_next = region_t'(3);
      floor_next  = 8'(3 * RegionSteps);
    end else if (hue < 8'(5 * RegionSteps)) begin
      region_next = region_t'(4);
      floor_next  = 8'(4 * RegionSteps);
    end else if (hue < 8'(6 * RegionSteps)) begin
      region_next = region_t'(5);
      floor_next  = 8'(5 * RegionSteps);
    end else begin
      region_next = RegionInvalid;
      floor_next  = 8'(6 * RegionSteps);
    end
    offset_next = hue - floor_next;
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_region <= region_next;
      // Out-of-range offsets are not looked up; the color is black anyway.
      s1_ramp   <= (offset_next < 8'(RegionSteps)) ? RampLut[offset_next[5:0]] : 8'd0;
      s1_light  <= lightness;
    end
  end

  // Stage 2: base color from the region, and the lightness factor.
  always_comb begin
    r_next = 8'd0;
    g_next = 8'd0;
    b_next = 8'd0;
    unique case (s1_region)
      region_t'(0): begin r_next = 8'hFF;           g_next = s1_ramp;         end
      region_t'(1): begin r_next = 8'hFF - s1_ramp; g_next = 8'hFF;           end
      region_t'(2): begin g_next = 8'hFF;           b_next = s1_ramp;         end
      region_t'(3): begin g_next = 8'hFF - s1_ramp; b_next = 8'hFF;           end
      region_t'(4): begin r_next = s1_ramp;         b_next = 8'hFF;           end
      region_t'(5): begin r_next = 8'hFF;           b_next = 8'hFF - s1_ramp; end
      default: begin
      end
    endcase
    if (s1_light < 8'd127) begin
      mode_next = SH_DARK;
      k_next    = 8'd128 - s1_light;
    end else if (s1_light > 8'd127) begin
      mode_next = SH_BRIGHT;
      k_next    = s1_light - 8'd128;
    end else begin
      mode_next = SH_PASS;
      k_next    = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_r    <= r_next;
      s2_g    <= g_next;
      s2_b    <= b_next;
      s2_k    <= k_next;
      s2_mode <= mode_next;
      s2_bad  <= (s1_region >= RegionInvalid);
    end
  end

  // Stages 3 and 4: shading of each channel.
  hlrgb_shade u_shade_r (
    .clk    (clk),
    .ctl    (ctl),
    .base   (s2_r),
    .mode   (s2_mode),
    .k      (s2_k),
    .result (red)
  );

  hlrgb_shade u_shade_g (
    .clk    (clk),
    .ctl    (ctl),
    .base   (s2_g),
    .mode   (s2_mode),
    .k      (s2_k),
    .result (green)
  );

  hlrgb_shade u_shade_b (
    .clk    (clk),
    .ctl    (ctl),
    .base   (s2_b),
    .mode   (s2_mode),
    .k      (s2_k),
    .result (blue)
  );

  // The invalid flag follows the channels through the last two stages.
  always_ff @(posedge clk) begin
    if (en3)    s3_bad      <= s2_bad;
    if (en_out) hue_invalid <= s3_bad;
  end

endmodule

// ===== rtl/hlrgb_shade.sv =====
// Lightness shading of one color channel: a multiply stage and a divide stage.
// Depends on hlrgb_pkg for the mode codes and the stage control struct.
`timescale 1ns / 1ps

module hlrgb_shade (
  input  logic                clk,
  input  hlrgb_pkg::shade_ctl_t ctl,
  input  logic [7:0]          base,
  input  hlrgb_pkg::shade_mode_t mode,
  input  logic [7:0]          k,
  output logic [7:0]          result
);
  import hlrgb_pkg::*;

  logic [7:0]  operand;
  logic [15:0] prod_full;
  logic [14:0] prod;
  logic [7:0]  base_d;
  shade_mode_t mode_d;

  logic [7:0] q0;
  logic [8:0] rem0;
  logic [7:0] q_bright;
  logic [7:0] result_next;

  // Darkening scales the channel, washing scales its distance to white.
  always_comb begin
    operand   = (mode == SH_BRIGHT) ? (8'hFF - base) : base;
    prod_full = operand * k;
  end

  // Product stage: the largest product is 255 * 128, which fits 15 bits.
  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod   <= prod_full[14:0];
      base_d <= base;
      mode_d <= mode;
    end
  end

  // Divide by 128 (dark) or by 127 (bright: /128 corrected by up to three).
  always_comb begin
    q0       = prod[14:7];
    rem0     = {2'b00, prod[6:0]} + {1'b0, q0};
    q_bright = q0 + 8'(rem0 >= 9'd127) + 8'(rem0 >= 9'd254) + 8'(rem0 >= 9'd381);
    unique case (mode_d)
      SH_DARK:   result_next = base_d - q0;
      SH_BRIGHT: result_next = base_d + q_bright;
      default:   result_next = base_d;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      result <= result_next;
    end
  end

endmodule

// ===== verif/tb_hue_lightness_to_rgb.sv =====
// Self-checking testbench for the hue/lightness to RGB converter.
// Drives pixel beats with random idling and back-pressure, predicts each color, checks the rgb channel.
// Depends on hlrgb_pkg and the hue_lightness_to_rgb RTL.
`timescale 1ns / 1ps

module tb_hue_lightness_to_rgb;
  import hlrgb_pkg::*;

  // One pixel to send; hold_for_drain makes the sender wait until no color is outstanding.
  typedef struct {
    logic [7:0] hue;
    logic [7:0] lightness;
    bit         hold_for_drain;
  } pixel_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       hue_invalid;
  } color_t;

  localparam int NumRandom  = 1200;
  localparam int HoldCycles = 80;
  localparam logic [7:0] EdgeLevels [6] = '{8'd0, 8'd126, 8'd127, 8'd128, 8'd129, 8'd255};

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       hl_valid = 1'b0;
  logic       hl_stall;
  logic [7:0] hue = 8'd0;
  logic [7:0] lightness = 8'd0;
  logic       rgb_valid;
  logic       rgb_stall = 1'b0;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       hue_invalid;

  pixel_t pixels_to_send [$];
  color_t colors_expected [$];
  int     pixels_taken = 0;
  int     colors_seen = 0;
  int     errors = 0;
  int     hold_left = 0;
  bit     hold_done = 1'b0;
  pixel_t next_pixel;
  color_t want;

  hue_lightness_to_rgb dut (
    .clk        (clk),
    .rst        (rst),
    .hl_valid   (hl_valid),
    .hl_stall   (hl_stall),
    .hue        (hue),
    .lightness  (lightness),
    .rgb_valid  (rgb_valid),
    .rgb_stall  (rgb_stall),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .hue_invalid(hue_invalid)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Lightness below 127 darkens toward black, above 127 washes toward white.
  function automatic logic [7:0] shade_level(int c, logic [7:0] l);
    int lv;
    lv = l;
    if (lv < 127) begin
      c = c - (c * (128 - lv)) / 128;
    end else if (lv > 127) begin
      c = c + ((FullScale - c) * (lv - 128)) / 127;
    end
    return c[7:0];
  endfunction

  // Full-saturation color for a hue, then shaded by lightness.
  function automatic color_t hue_to_color(logic [7:0] h, logic [7:0] l);
    int     hv, region, ramp, r, g, b;
    color_t res;
    hv = h;
    region = hv / RegionSteps;
    ramp = ((hv - region * RegionSteps) * FullScale) / RegionSteps;
    res.hue_invalid = 1'b0;
    // Each region holds one channel at full, one at zero and ramps the third.
    case (region)
      0: begin r = FullScale;        g = ramp;             b = 0; end
      1: begin r = FullScale - ramp; g = FullScale;        b = 0; end
      2: begin r = 0;                g = FullScale;        b = ramp; end
      3: begin r = 0;                g = FullScale - ramp; b = FullScale; end
      4: begin r = ramp;             g = 0;                b = FullScale; end
      5: begin r = FullScale;        g = 0;                b = FullScale - ramp; end
      default: begin
        r = 0;
        g = 0;
        b = 0;
        res.hue_invalid = 1'b1;
      end
    endcase
    res.red = shade_level(r, l);
    res.green = shade_level(g, l);
    res.blue = shade_level(b, l);
    return res;
  endfunction

  // Idle rates per phase: sender light and receiver heavy, then swapped, then none.
  function automatic int sender_idle_pct(int n);
    return (n < 400) ? 18 : (n < 800) ? 63 : 0;
  endfunction

  function automatic int receiver_idle_pct(int n);
    return (n < 400) ? 63 : (n < 800) ? 18 : 0;
  endfunction

  task automatic check_field(string name, int got, int exp_val);
    if (got != exp_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got);
      errors++;
    end
  endtask

  task automatic add_pixel(int h, int l, bit drain);
    pixel_t p;
    p.hue = h[7:0];
    p.lightness = l[7:0];
    p.hold_for_drain = drain;
    pixels_to_send.push_back(p);
  endtask

  // Sender: record each accepted beat's color, then offer the next pixel or idle.
  always @(posedge clk) begin
    if (rst) begin
      hl_valid <= 1'b0;
    end else begin
      if (hl_valid && !hl_stall) begin
        colors_expected.push_back(hue_to_color(hue, lightness));
        pixels_taken++;
      end
      if (!hl_valid || !hl_stall) begin
        if (pixels_to_send.size() != 0
            && !(pixels_to_send[0].hold_for_drain && colors_expected.size() != 0)
            && $urandom_range(0, 99) >= sender_idle_pct(pixels_taken)) begin
          next_pixel = pixels_to_send.pop_front();
          hue <= next_pixel.hue;
          lightness <= next_pixel.lightness;
          hl_valid <= 1'b1;
        end else begin
          hl_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each accepted color against the oldest expectation, then set stall.
  always @(posedge clk) begin
    if (rst) begin
      rgb_stall <= 1'b0;
    end else begin
      if (rgb_valid && !rgb_stall) begin
        if (colors_expected.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got r=%0d g=%0d b=%0d inv=%0b",
                   $time, red, green, blue, hue_invalid);
          errors++;
        end else begin
          want = colors_expected.pop_front();
          check_field("red", red, want.red);
          check_field("green", green, want.green);
          check_field("blue", blue, want.blue);
          check_field("hue_invalid", hue_invalid, want.hue_invalid);
        end
        colors_seen++;
      end
      // One long hold-off while the sender runs flat out, so the pipeline backs up.
      if (!hold_done && colors_seen >= 1000) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        rgb_stall <= 1'b1;
      end else begin
        rgb_stall <= ($urandom_range(0, 99) < receiver_idle_pct(colors_seen));
      end
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int h, l;
    // Region edges, out-of-range hues and the lightness extremes.
    add_pixel(0, 127, 0);   add_pixel(39, 128, 0);  add_pixel(40, 127, 0);
    add_pixel(79, 127, 0);  add_pixel(80, 128, 0);  add_pixel(119, 127, 0);
    add_pixel(120, 127, 0); add_pixel(159, 128, 0); add_pixel(160, 127, 0);
    add_pixel(199, 127, 0); add_pixel(200, 128, 0); add_pixel(239, 127, 0);
    add_pixel(240, 0, 0);   add_pixel(255, 255, 0); add_pixel(240, 200, 0);
    add_pixel(255, 128, 0); add_pixel(20, 0, 0);    add_pixel(20, 126, 0);
    add_pixel(20, 129, 0);  add_pixel(20, 255, 0);  add_pixel(100, 64, 0);
    add_pixel(180, 192, 0); add_pixel(0, 255, 0);   add_pixel(239, 0, 0);
    // Mostly valid hues; lightness often lands on a shading boundary.
    for (int i = 0; i < NumRandom; i++) begin
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(240, 255) : $urandom_range(0, 239);
      l = ($urandom_range(0, 6) == 0) ? EdgeLevels[$urandom_range(0, 5)]
                                      : $urandom_range(0, 255);
      add_pixel(h, l, (i == 0 || i == 1080));
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pixels_to_send.size() != 0 || hl_valid) @(posedge clk);
    while (colors_expected.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0 && colors_expected.size() == 0) begin
      $display("hue_lightness_to_rgb test passed");
    end else begin
      $display("hue_lightness_to_rgb test failed");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("hue_lightness_to_rgb test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hlrgb_pkg.sv
rtl/hlrgb_shade.sv
rtl/hue_lightness_to_rgb.sv
verif/tb_hue_lightness_to_rgb.sv
